// ===== rtl/priority_round_robin_scheduler_assert.svh =====
// Assertion macros shared by the scheduler RTL
`ifndef PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define PRIORITY_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define PRRS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("scheduler invariant violated");

// consequent holds in the same cycle as the antecedent
`define PRRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler implication violated");

`endif

// ===== rtl/prrs_pkg.sv =====
// Types and constants of the priority round-robin scheduler
`default_nettype none

package prrs_pkg;

  localparam int ID_W   = 8;
  localparam int PRIO_W = 4;
  localparam int LEN_W  = 16;

  localparam logic [LEN_W-1:0] QUANTUM_RESET = 16'd10;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_SLICE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ADDED = 2'd0,
    STATUS_SLICE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_t;

  // one task table entry
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  rem;
  } entry_t;

  // one request from the command channel
  typedef struct packed {
    logic              op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  burst;
  } cmd_t;

  // one result toward the output channel
  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   slice_task;
    logic [LEN_W-1:0]  slice_length;
    logic              task_finished;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/prrs_core.sv =====
// Task table memory and the insertion sequencer with its priority comparator
`default_nettype none
`include "priority_round_robin_scheduler_assert.svh"

module prrs_core #(
  parameter int MAX_TASKS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cmd_valid,
  input  wire prrs_pkg::cmd_t                 cmd,
  input  wire logic [prrs_pkg::LEN_W-1:0]     quantum,
  output logic                                done,
  output prrs_pkg::result_t                   res
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int SUM_W = IDX_W + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_PUT
  } state_t;

  // circular buffer pointer steps
  function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
    ptr_inc = (p == IDX_W'(MAX_TASKS - 1)) ? '0 : p + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
    ptr_dec = (p == '0) ? IDX_W'(MAX_TASKS - 1) : p - IDX_W'(1);
  endfunction

  state_t                         state_r, state_nxt;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [IDX_W-1:0]               tail_r, tail_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [IDX_W-1:0]               wr_ptr_r, wr_ptr_nxt;
  logic [IDX_W-1:0]               rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]               k_r, k_nxt;
  prrs_pkg::entry_t               ins_r, ins_nxt;
  prrs_pkg::result_t              res_r, res_nxt;

  prrs_pkg::entry_t               mem [MAX_TASKS];
  prrs_pkg::entry_t               rd_q;
  logic                           mem_we;
  logic [IDX_W-1:0]               mem_wa;
  prrs_pkg::entry_t               mem_wd;
  logic [IDX_W-1:0]               mem_ra;

  logic                           full;
  logic                           empty;
  logic [prrs_pkg::LEN_W-1:0]     rem_left;
  logic [SUM_W-1:0]               tail_sum;
  logic [IDX_W-1:0]               tail_chk;

  assign full     = (count_r == CNT_W'(MAX_TASKS));
  assign empty    = (count_r == '0);
  assign rem_left = rd_q.rem - quantum;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    k_nxt      = k_r;
    ins_nxt    = ins_r;
    res_nxt    = res_r;
    mem_we     = 1'b0;
    mem_wa     = wr_ptr_r;
    mem_wd     = ins_r;
    mem_ra     = ptr_dec(rd_ptr_r);
    done       = 1'b0;
    res        = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == prrs_pkg::OP_ADD) begin
            if (full) begin
              done = 1'b1;
              res  = '{prrs_pkg::STATUS_FULL, '0, '0, 1'b0};
            end else begin
              ins_nxt    = '{cmd.id, cmd.prio, cmd.burst};
              res_nxt    = '{prrs_pkg::STATUS_ADDED, '0, '0, 1'b0};
              wr_ptr_nxt = tail_r;
              rd_ptr_nxt = ptr_dec(tail_r);
              mem_ra     = ptr_dec(tail_r);
              k_nxt      = count_r;
              state_nxt  = empty ? S_PUT : S_WALK;
            end
          end else begin
            if (empty) begin
              done = 1'b1;
              res  = '{prrs_pkg::STATUS_EMPTY, '0, '0, 1'b0};
            end else begin
              mem_ra    = head_r;
              state_nxt = S_DECIDE;
            end
          end
        end
      end

      // head entry is on rd_q
      S_DECIDE: begin
        if (rd_q.rem <= quantum) begin
          done      = 1'b1;
          res       = '{prrs_pkg::STATUS_SLICE, rd_q.id, rd_q.rem, 1'b1};
          head_nxt  = ptr_inc(head_r);
          count_nxt = count_r - CNT_W'(1);
          state_nxt = S_IDLE;
        end else if (count_r == CNT_W'(1)) begin
          // lone task keeps the head slot
          mem_we    = 1'b1;
          mem_wa    = head_r;
          mem_wd    = '{rd_q.id, rd_q.prio, rem_left};
          done      = 1'b1;
          res       = '{prrs_pkg::STATUS_SLICE, rd_q.id, quantum, 1'b0};
          state_nxt = S_IDLE;
        end else begin
          // pop the head and requeue it behind its peers
          head_nxt   = ptr_inc(head_r);
          count_nxt  = count_r - CNT_W'(1);
          ins_nxt    = '{rd_q.id, rd_q.prio, rem_left};
          res_nxt    = '{prrs_pkg::STATUS_SLICE, rd_q.id, quantum, 1'b0};
          wr_ptr_nxt = tail_r;
          rd_ptr_nxt = ptr_dec(tail_r);
          mem_ra     = ptr_dec(tail_r);
          k_nxt      = count_r - CNT_W'(1);
          state_nxt  = S_WALK;
        end
      end

      // entry k-1 is on rd_q; shift it up while it is less urgent
      S_WALK: begin
        mem_we = 1'b1;
        if (rd_q.prio > ins_r.prio) begin
          mem_wd     = rd_q;
          wr_ptr_nxt = rd_ptr_r;
          rd_ptr_nxt = ptr_dec(rd_ptr_r);
          k_nxt      = k_r - CNT_W'(1);
          if (k_r == CNT_W'(1)) begin
            state_nxt = S_PUT;
          end
        end else begin
          count_nxt = count_r + CNT_W'(1);
          tail_nxt  = ptr_inc(tail_r);
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // new entry lands at the front of the walk
      S_PUT: begin
        mem_we    = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        tail_nxt  = ptr_inc(tail_r);
        done      = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered sequencer outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
    wr_ptr_r <= wr_ptr_nxt;
    rd_ptr_r <= rd_ptr_nxt;
    k_r      <= k_nxt;
    ins_r    <= ins_nxt;
    res_r    <= res_nxt;
  end

  // expected tail from head and count, for checking only
  assign tail_sum = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_chk = (tail_sum >= SUM_W'(MAX_TASKS)) ?
                    IDX_W'(tail_sum - SUM_W'(MAX_TASKS)) : IDX_W'(tail_sum);

  `PRRS_ASSERT_ALWAYS(a_count_range, clk, rst_n, count_r <= CNT_W'(MAX_TASKS))
  `PRRS_ASSERT_ALWAYS(a_tail_follows_head, clk, rst_n, tail_r == tail_chk)
  `PRRS_ASSERT_IMPL(a_walk_bounds, clk, rst_n, state_r == S_WALK, (k_r != '0) && (k_r <= count_r))

endmodule

`default_nettype wire

// ===== rtl/priority_round_robin_scheduler.sv =====
// Top level of the priority round-robin scheduler
//
// Usage:
//   Command channel: a request (in_operation, in_task_id, in_priority_req,
//   in_burst) is taken at a clock edge with start high and busy low. busy
//   stays high while the request is worked on.
//   Result channel: every request yields exactly one result. out_valid is
//   high for one cycle with out_status, out_slice_task, out_slice_length and
//   out_task_finished; the receiver cannot stall it, so it must sample then.
//   Config channel: cfg_quantum is written when cfg_valid and cfg_ready are
//   high; cfg_ready is low while a request is in progress.
//   Timing: a full table or an empty queue gives its result at the accepting
//   edge; a slice that finishes or keeps a lone task in place reads the head
//   entry first; an add walks up from the tail, a requeue reads the head and
//   then walks. The walk moves one entry per cycle through the table's read
//   and write ports and one priority comparator; busy drops at the edge that
//   raises out_valid, so a new start may be taken in that cycle.
//   Reset: synchronous, active low; empties the table and sets the quantum
//   to 10. Table contents are not cleared.
`default_nettype none
`include "priority_round_robin_scheduler_assert.svh"

module priority_round_robin_scheduler #(
  parameter int MAX_TASKS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // command channel
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             in_operation,
  input  wire logic [prrs_pkg::ID_W-1:0]        in_task_id,
  input  wire logic [prrs_pkg::PRIO_W-1:0]      in_priority_req,
  input  wire logic [prrs_pkg::LEN_W-1:0]       in_burst,
  // result channel
  output logic                                  out_valid,
  output logic [1:0]                            out_status,
  output logic [prrs_pkg::ID_W-1:0]             out_slice_task,
  output logic [prrs_pkg::LEN_W-1:0]            out_slice_length,
  output logic                                  out_task_finished,
  // config channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [prrs_pkg::LEN_W-1:0]       cfg_quantum
);

  logic                           busy_r, busy_nxt;
  logic                           out_valid_r;
  logic [prrs_pkg::LEN_W-1:0]     quantum_r;
  prrs_pkg::result_t              out_r;
  logic                           accept;
  logic                           cfg_write;
  prrs_pkg::cmd_t                 cmd;
  logic                           core_done;
  prrs_pkg::result_t              core_res;

  assign accept    = start && !busy_r;
  assign cfg_ready = !busy_r;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cmd       = '{in_operation, in_task_id, in_priority_req, in_burst};

  // busy from accept to completion
  assign busy_nxt = core_done ? 1'b0 : (accept ? 1'b1 : busy_r);

  prrs_core #(
    .MAX_TASKS (MAX_TASKS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (accept),
    .cmd       (cmd),
    .quantum   (quantum_r),
    .done      (core_done),
    .res       (core_res)
  );

  // control registers and quantum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      quantum_r   <= prrs_pkg::QUANTUM_RESET;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= core_done;
      if (cfg_write) begin
        quantum_r <= cfg_quantum;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (core_done) begin
      out_r <= core_res;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_slice_task    = out_r.slice_task;
  assign out_slice_length  = out_r.slice_length;
  assign out_task_finished = out_r.task_finished;

  `PRRS_ASSERT_IMPL(a_result_after_busy, clk, rst_n, out_valid_r, !busy_r)
  `PRRS_ASSERT_IMPL(a_finish_is_slice, clk, rst_n, out_valid_r && out_r.task_finished, out_r.status == prrs_pkg::STATUS_SLICE)

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Testbench for the priority round-robin scheduler: directed and random requests
`timescale 1ns / 100ps

module tb;

  localparam int TABLE_DEPTH  = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_REQS  = 950;

  // kinds of entries in the stimulus queue
  typedef enum logic [1:0] {
    SEND_REQ,
    SET_QUANTUM,
    DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t                     kind;
    prrs_pkg::cmd_t                 cmd;
    logic [prrs_pkg::LEN_W-1:0]     quantum;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_operation = prrs_pkg::OP_ADD;
  logic [prrs_pkg::ID_W-1:0] in_task_id = '0;
  logic [prrs_pkg::PRIO_W-1:0] in_priority_req = '0;
  logic [prrs_pkg::LEN_W-1:0] in_burst = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [prrs_pkg::ID_W-1:0] out_slice_task;
  logic [prrs_pkg::LEN_W-1:0] out_slice_length;
  logic out_task_finished;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [prrs_pkg::LEN_W-1:0] cfg_quantum = '0;

  stim_t             pending_reqs[$];
  prrs_pkg::result_t results_due[$];
  logic              req_taken = 1'b0;
  logic              cfg_taken = 1'b0;
  int                err_count = 0;
  int                cycle_count = 0;
  int                gap_left = 0;
  int                quiet_left = 0;

  // scheduler shadow: task table and quantum
  logic [prrs_pkg::ID_W-1:0]   sched_id[TABLE_DEPTH];
  logic [prrs_pkg::PRIO_W-1:0] sched_prio[TABLE_DEPTH];
  logic [prrs_pkg::LEN_W-1:0]  sched_rem[TABLE_DEPTH];
  int                          sched_cnt;
  logic [prrs_pkg::LEN_W-1:0]  sched_quantum;

  priority_round_robin_scheduler #(
    .MAX_TASKS(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operation(in_operation),
    .in_task_id(in_task_id),
    .in_priority_req(in_priority_req),
    .in_burst(in_burst),
    .out_valid(out_valid),
    .out_status(out_status),
    .out_slice_task(out_slice_task),
    .out_slice_length(out_slice_length),
    .out_task_finished(out_task_finished),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_quantum(cfg_quantum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // insert behind every entry of equal or better priority
  function automatic void table_put(input logic [prrs_pkg::ID_W-1:0] id,
                                    input logic [prrs_pkg::PRIO_W-1:0] pr,
                                    input logic [prrs_pkg::LEN_W-1:0] rem);
    int pos;
    pos = 0;
    while (pos < sched_cnt && sched_prio[pos] <= pr) pos++;
    for (int k = sched_cnt; k > pos; k--) begin
      sched_id[k]   = sched_id[k-1];
      sched_prio[k] = sched_prio[k-1];
      sched_rem[k]  = sched_rem[k-1];
    end
    sched_id[pos]   = id;
    sched_prio[pos] = pr;
    sched_rem[pos]  = rem;
    sched_cnt++;
  endfunction

  function automatic void table_drop_head();
    for (int k = 1; k < sched_cnt; k++) begin
      sched_id[k-1]   = sched_id[k];
      sched_prio[k-1] = sched_prio[k];
      sched_rem[k-1]  = sched_rem[k];
    end
    if (sched_cnt > 0) sched_cnt--;
  endfunction

  // expected result of one request; updates the shadow table
  function automatic prrs_pkg::result_t predict_request(input prrs_pkg::cmd_t c);
    prrs_pkg::result_t           r;
    logic [prrs_pkg::ID_W-1:0]   hid;
    logic [prrs_pkg::PRIO_W-1:0] hprio;
    logic [prrs_pkg::LEN_W-1:0]  hrem;
    r.status        = prrs_pkg::STATUS_ADDED;
    r.slice_task    = '0;
    r.slice_length  = '0;
    r.task_finished = 1'b0;
    if (c.op == prrs_pkg::OP_ADD) begin
      if (sched_cnt >= TABLE_DEPTH) r.status = prrs_pkg::STATUS_FULL;
      else table_put(c.id, c.prio, c.burst);
    end else if (sched_cnt == 0) begin
      r.status = prrs_pkg::STATUS_EMPTY;
    end else begin
      hid   = sched_id[0];
      hprio = sched_prio[0];
      hrem  = sched_rem[0];
      r.status     = prrs_pkg::STATUS_SLICE;
      r.slice_task = hid;
      if (hrem <= sched_quantum) begin
        r.slice_length  = hrem;
        r.task_finished = 1'b1;
        table_drop_head();
      end else begin
        r.slice_length = sched_quantum;
        hrem = hrem - sched_quantum;
        if (sched_cnt == 1) begin
          sched_rem[0] = hrem;
        end else begin
          table_drop_head();
          table_put(hid, hprio, hrem);
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // idle length between requests: mostly none or short, a few long
  function automatic int pick_gap();
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [prrs_pkg::LEN_W-1:0] pick_burst(
      input logic [prrs_pkg::LEN_W-1:0] q);
    int upper;
    upper = (q == 0) ? 20 : ((int'(q) * 3 > 65535) ? 65535 : int'(q) * 3);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return prrs_pkg::LEN_W'($urandom_range(0, 65535));
      default: return prrs_pkg::LEN_W'($urandom_range(0, upper));
    endcase
  endfunction

  task automatic push_cmd(input logic op, input logic [prrs_pkg::ID_W-1:0] id,
                          input logic [prrs_pkg::PRIO_W-1:0] pr,
                          input logic [prrs_pkg::LEN_W-1:0] b);
    stim_t s;
    s.kind      = SEND_REQ;
    s.cmd.op    = op;
    s.cmd.id    = id;
    s.cmd.prio  = pr;
    s.cmd.burst = b;
    s.quantum   = '0;
    pending_reqs.push_back(s);
  endtask

  task automatic push_quantum(input logic [prrs_pkg::LEN_W-1:0] q);
    stim_t s;
    s.kind    = SET_QUANTUM;
    s.cmd     = '0;
    s.quantum = q;
    pending_reqs.push_back(s);
  endtask

  task automatic push_drain();
    stim_t s;
    s.kind    = DRAIN;
    s.cmd     = '0;
    s.quantum = '0;
    pending_reqs.push_back(s);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk) begin : drive_proc
    logic nxt_start;
    logic nxt_cfg;
    nxt_start = start;
    nxt_cfg   = cfg_valid;
    if (!rst_n) begin
      nxt_start = 1'b0;
      nxt_cfg   = 1'b0;
    end else begin
      if (start && req_taken) begin
        nxt_start = 1'b0;
        gap_left  = pick_gap();
      end
      if (cfg_valid && cfg_taken) begin
        nxt_cfg  = 1'b0;
        gap_left = pick_gap();
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0) begin
          case (pending_reqs[0].kind)
            SEND_REQ: begin
              nxt_start       = 1'b1;
              in_operation    <= pending_reqs[0].cmd.op;
              in_task_id      <= pending_reqs[0].cmd.id;
              in_priority_req <= pending_reqs[0].cmd.prio;
              in_burst        <= pending_reqs[0].cmd.burst;
              void'(pending_reqs.pop_front());
            end
            SET_QUANTUM: begin
              if (results_due.size() == 0) begin
                nxt_cfg     = 1'b1;
                cfg_quantum <= pending_reqs[0].quantum;
                void'(pending_reqs.pop_front());
              end
            end
            default: begin
              if (results_due.size() == 0) void'(pending_reqs.pop_front());
            end
          endcase
        end
      end
    end
    start     <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // monitor: handshakes and results sampled on the rising edge
  always @(posedge clk) begin : monitor_proc
    prrs_pkg::result_t exp_r;
    prrs_pkg::cmd_t    c;
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("tb: done, errors");
      $finish;
    end else if (!rst_n) begin
      req_taken     <= 1'b0;
      cfg_taken     <= 1'b0;
      sched_cnt     = 0;
      sched_quantum = prrs_pkg::QUANTUM_RESET;
    end else begin
      if (out_valid) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          exp_r = results_due.pop_front();
          if (out_status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_r.status));
          if (out_slice_task !== exp_r.slice_task)
            report_mismatch($sformatf("slice_task %0h, expected %0h",
                                      out_slice_task, exp_r.slice_task));
          if (out_slice_length !== exp_r.slice_length)
            report_mismatch($sformatf("slice_length %0d, expected %0d",
                                      out_slice_length, exp_r.slice_length));
          if (out_task_finished !== exp_r.task_finished)
            report_mismatch($sformatf("task_finished %0b, expected %0b",
                                      out_task_finished, exp_r.task_finished));
        end
      end
      req_taken <= start && !busy;
      cfg_taken <= cfg_valid && cfg_ready;
      if (start && !busy) begin
        c.op    = in_operation;
        c.id    = in_task_id;
        c.prio  = in_priority_req;
        c.burst = in_burst;
        results_due.push_back(predict_request(c));
      end
      if (cfg_valid && cfg_ready) sched_quantum = cfg_quantum;
    end
  end

  // stimulus, reset and end of run
  initial begin : stim_proc
    int                         n_reqs;
    int                         n_ep;
    int                         add_pct;
    logic [prrs_pkg::LEN_W-1:0] q;

    q = prrs_pkg::QUANTUM_RESET;

    // directed: empty queue, extremes, zero burst, FIFO among peers
    push_cmd(prrs_pkg::OP_SLICE, 8'h00, 4'h0, 16'h0000);
    push_cmd(prrs_pkg::OP_ADD, 8'h00, 4'h0, 16'h0000);
    push_cmd(prrs_pkg::OP_ADD, 8'hFF, 4'hF, 16'hFFFF);
    push_cmd(prrs_pkg::OP_ADD, 8'hA5, 4'hF, 16'd25);
    push_cmd(prrs_pkg::OP_ADD, 8'h5A, 4'h7, 16'd10);
    push_cmd(prrs_pkg::OP_ADD, 8'h11, 4'h7, 16'd11);
    repeat (6) push_cmd(prrs_pkg::OP_SLICE, 8'h00, 4'h0, 16'h0000);
    // zero quantum: no progress, tasks rotate among peers
    push_quantum(16'd0);
    push_cmd(prrs_pkg::OP_SLICE, 8'h00, 4'h0, 16'h0000);
    push_cmd(prrs_pkg::OP_ADD, 8'h3C, 4'hF, 16'h0000);
    repeat (3) push_cmd(prrs_pkg::OP_SLICE, 8'h00, 4'h0, 16'h0000);
    // largest quantum: everything finishes in one slice
    push_quantum(16'hFFFF);
    repeat (3) push_cmd(prrs_pkg::OP_SLICE, 8'h00, 4'h0, 16'h0000);
    // lone task stays at the head
    push_quantum(16'd1);
    push_cmd(prrs_pkg::OP_ADD, 8'h42, 4'h3, 16'd3);
    repeat (3) push_cmd(prrs_pkg::OP_SLICE, 8'h00, 4'h0, 16'h0000);

    // random episodes; most set a new quantum first, the rest drain first
    n_reqs = 0;
    while (n_reqs < RANDOM_REQS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       q = 16'd1;
          1:       q = 16'hFFFF;
          2:       q = 16'd0;
          3:       q = prrs_pkg::QUANTUM_RESET;
          4, 5:    q = prrs_pkg::LEN_W'($urandom_range(1, 65535));
          default: q = prrs_pkg::LEN_W'($urandom_range(2, 64));
        endcase
        push_quantum(q);
      end else begin
        push_drain();
      end
      if ($urandom_range(0, 4) == 0) begin
        // flood past a full table, then serve it down
        n_ep = TABLE_DEPTH + $urandom_range(2, 6);
        repeat (n_ep) push_cmd(prrs_pkg::OP_ADD, prrs_pkg::ID_W'($urandom_range(0, 255)),
                               prrs_pkg::PRIO_W'($urandom_range(0, 15)), pick_burst(q));
        repeat (n_ep + 4) push_cmd(prrs_pkg::OP_SLICE,
                                   prrs_pkg::ID_W'($urandom_range(0, 255)),
                                   prrs_pkg::PRIO_W'($urandom_range(0, 15)),
                                   prrs_pkg::LEN_W'($urandom_range(0, 65535)));
        n_reqs += 2 * n_ep + 4;
      end else begin
        n_ep    = $urandom_range(20, 60);
        add_pct = $urandom_range(30, 70);
        repeat (n_ep) begin
          if ($urandom_range(0, 99) < add_pct)
            push_cmd(prrs_pkg::OP_ADD, prrs_pkg::ID_W'($urandom_range(0, 255)),
                     prrs_pkg::PRIO_W'($urandom_range(0, 15)), pick_burst(q));
          else
            push_cmd(prrs_pkg::OP_SLICE, prrs_pkg::ID_W'($urandom_range(0, 255)),
                     prrs_pkg::PRIO_W'($urandom_range(0, 15)),
                     prrs_pkg::LEN_W'($urandom_range(0, 65535)));
        end
        n_reqs += n_ep;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || cfg_valid || results_due.size() != 0);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (results_due.size() != 0) report_mismatch("results still outstanding at end of run");

    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
